// ===== rtl/ksl_pkg.sv =====
// Shared types and constants for the keyed slot table.
package ksl_pkg;

    localparam int DEF_TABLE_SLOTS = 4;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int TYPE_W   = 8;
    localparam int HANDLE_W = 16;
    localparam int ROOT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS  = CMD_W + ID_W + TYPE_W + HANDLE_W + ROOT_W;
    localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + SLOT_W + TYPE_W + HANDLE_W;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // command held for the whole walk down the chain
    typedef struct packed {
        cmd_t                cmd;
        logic [ID_W-1:0]     id;
        logic [TYPE_W-1:0]   typ;
        logic [HANDLE_W-1:0] handle;
        logic [ROOT_W-1:0]   root;
    } req_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                done;
        logic [TYPE_W-1:0]   ftype;
        logic [HANDLE_W-1:0] fhandle;
    } tok_t;

endpackage

// ===== rtl/ksl_cell.sv =====
// One table slot: holds an entry and acts on the search token as it passes.
module ksl_cell
    import ksl_pkg::*;
#(
    parameter int  TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int  CELL_IDX    = 0,
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  req_t                   req,
    input  tok_t                   tok_in,
    input  logic [IDX_W-1:0]       idx_in,
    output tok_t                   tok_out,
    output logic [IDX_W-1:0]       idx_out
);

    logic                used_reg,   used_next;
    logic [ID_W-1:0]     id_reg,     id_next;
    logic [TYPE_W-1:0]   type_reg,   type_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [ROOT_W-1:0]   root_reg,   root_next;
    tok_t                tok_reg,    tok_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic                match;

    assign match = used_reg && (id_reg == req.id) && (root_reg == req.root);

    always_comb
    begin
        used_next   = used_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        handle_next = handle_reg;
        root_next   = root_reg;
        tok_next    = tok_in;
        idx_next    = idx_in;
        if (tok_in.valid && !tok_in.done)
        begin
            unique case (req.cmd)
                CMD_ADD:
                begin
                    if (!used_reg)
                    begin
                        used_next     = 1'b1;
                        id_next       = req.id;
                        type_next     = req.typ;
                        handle_next   = req.handle;
                        root_next     = req.root;
                        tok_next.done = 1'b1;
                        idx_next      = IDX_W'(CELL_IDX);
                    end
                end
                CMD_REMOVE:
                begin
                    if (match)
                    begin
                        used_next     = 1'b0;
                        tok_next.done = 1'b1;
                        idx_next      = IDX_W'(CELL_IDX);
                    end
                end
                CMD_LOOKUP:
                begin
                    if (match)
                    begin
                        tok_next.done    = 1'b1;
                        tok_next.ftype   = type_reg;
                        tok_next.fhandle = handle_reg;
                        idx_next         = IDX_W'(CELL_IDX);
                    end
                end
                CMD_CLEAR:
                begin
                    used_next = 1'b0;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            id_reg     <= id_next;
            type_reg   <= type_next;
            handle_reg <= handle_next;
            root_reg   <= root_next;
            idx_reg    <= idx_next;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== rtl/keyed_slot_table.sv =====
// Keyed slot table: top level with stream ports and the chain of slot cells.
// A command passes from the launch register through the token register of each cell to the result register.
// One command is in flight. The search token walks the chain one cell per
// cycle while the chain advances, and the next item is taken once the result
// is loaded. A waiting result does not block that accept, but it holds the
// whole chain until it is taken. Reset (rst_n low, asynchronous) frees every
// slot and empties the chain.
module keyed_slot_table
    import ksl_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    // s_axis_tdata: command[1:0], query_id[9:2], query_type[17:10],
    //               payload_handle[33:18], root_addr[49:34], zero pad
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // m_axis_tdata: status[1:0], slot_index[3:2], found_type[11:4],
    //               found_handle[27:12], zero pad
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic busy_reg,   busy_next;
    logic launch_reg, launch_next;
    req_t req_reg;
    logic out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg, out_data_next;

    logic    accept;
    logic    advance;
    tok_t    tok_chain [0:TABLE_SLOTS];
    logic [IDX_W-1:0] idx_chain [0:TABLE_SLOTS];
    tok_t    tok_last;
    logic [EXT_W-1:0] idx_ext;
    status_t res_status;

    // one command at a time: take a new item once the previous token left
    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // hold the whole chain while a finished token waits on a full output
    assign advance = !(out_valid_reg && !m_axis_tready);

    // inject a fresh token at the head of the chain
    assign tok_chain[0] = tok_t'({launch_reg, {(TYPE_W + HANDLE_W + 1){1'b0}}});
    assign idx_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            ksl_cell #(
                .TABLE_SLOTS (TABLE_SLOTS),
                .CELL_IDX    (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .req     (req_reg),
                .tok_in  (tok_chain[g]),
                .idx_in  (idx_chain[g]),
                .tok_out (tok_chain[g+1]),
                .idx_out (idx_chain[g+1])
            );
        end
    endgenerate

    assign tok_last = tok_chain[TABLE_SLOTS];
    assign idx_ext  = EXT_W'(idx_chain[TABLE_SLOTS]);

    // a token that found nothing reports by command: add means full,
    // clear always succeeds, remove and lookup mean the key is missing
    always_comb
    begin
        priority if (tok_last.done)
            res_status = ST_OK;
        else if (req_reg.cmd == CMD_ADD)
            res_status = ST_FULL;
        else if (req_reg.cmd == CMD_CLEAR)
            res_status = ST_OK;
        else
            res_status = ST_MISSING;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        launch_next    = launch_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
            out_valid_next = 1'b0;

        if (advance)
            launch_next = 1'b0;

        if (advance && tok_last.valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {tok_last.fhandle, tok_last.ftype,
                              idx_ext[SLOT_W-1:0], res_status};
            busy_next      = 1'b0;
        end

        if (accept)
        begin
            busy_next   = 1'b1;
            launch_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: capture the command and the result
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            req_reg.cmd    <= cmd_t'(s_axis_tdata[1:0]);
            req_reg.id     <= s_axis_tdata[9:2];
            req_reg.typ    <= s_axis_tdata[17:10];
            req_reg.handle <= s_axis_tdata[33:18];
            req_reg.root   <= s_axis_tdata[49:34];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'(out_data_reg);

endmodule

// ===== tb/keyed_slot_table_test.sv =====
// Stream-level testbench for the keyed slot table: random and directed commands, scoreboard check.

// One expected result item, field by field.
typedef struct {
    ksl_pkg::status_t                   status;
    logic [ksl_pkg::SLOT_W-1:0]         slot;
    logic [ksl_pkg::TYPE_W-1:0]         ftype;
    logic [ksl_pkg::HANDLE_W-1:0]       fhandle;
} slot_reply_t;

// Shadow copy of the table plus the queue of replies still owed by the block.
class slot_table_board;
    bit                                 slot_busy   [ksl_pkg::DEF_TABLE_SLOTS];
    logic [ksl_pkg::ID_W-1:0]           slot_id     [ksl_pkg::DEF_TABLE_SLOTS];
    logic [ksl_pkg::TYPE_W-1:0]         slot_type   [ksl_pkg::DEF_TABLE_SLOTS];
    logic [ksl_pkg::HANDLE_W-1:0]       slot_handle [ksl_pkg::DEF_TABLE_SLOTS];
    logic [ksl_pkg::ROOT_W-1:0]         slot_root   [ksl_pkg::DEF_TABLE_SLOTS];
    slot_reply_t                        awaited_replies[$];
    int unsigned                        failures;
    int unsigned                        taken;

    function new();
        failures = 0;
        taken    = 0;
        wipe_table();
    endfunction

    function void wipe_table();
        for (int s = 0; s < ksl_pkg::DEF_TABLE_SLOTS; s++)
        begin
            free_slot(s);
        end
    endfunction

    function void free_slot(int s);
        slot_busy[s]   = 1'b0;
        slot_id[s]     = '0;
        slot_type[s]   = '0;
        slot_handle[s] = '0;
        slot_root[s]   = '0;
    endfunction

    // Lowest busy slot holding the key; free slots never match.
    function int find_key(logic [ksl_pkg::ID_W-1:0] id, logic [ksl_pkg::ROOT_W-1:0] root);
        for (int s = 0; s < ksl_pkg::DEF_TABLE_SLOTS; s++)
        begin
            if (slot_busy[s] && slot_id[s] == id && slot_root[s] == root)
                return s;
        end
        return -1;
    endfunction

    // Apply one accepted command to the shadow table and queue its reply.
    function void note_command(ksl_pkg::req_t r);
        slot_reply_t rep;
        int          hit;
        rep.status  = ksl_pkg::ST_OK;
        rep.slot    = '0;
        rep.ftype   = '0;
        rep.fhandle = '0;
        hit         = -1;
        case (r.cmd)
            ksl_pkg::CMD_ADD:
            begin
                for (int s = ksl_pkg::DEF_TABLE_SLOTS - 1; s >= 0; s--)
                begin
                    if (!slot_busy[s])
                        hit = s;
                end
                if (hit >= 0)
                begin
                    slot_busy[hit]   = 1'b1;
                    slot_id[hit]     = r.id;
                    slot_type[hit]   = r.typ;
                    slot_handle[hit] = r.handle;
                    slot_root[hit]   = r.root;
                    rep.slot         = hit[ksl_pkg::SLOT_W-1:0];
                end
                else
                begin
                    rep.status = ksl_pkg::ST_FULL;
                end
            end
            ksl_pkg::CMD_REMOVE:
            begin
                hit = find_key(r.id, r.root);
                if (hit >= 0)
                begin
                    free_slot(hit);
                    rep.slot = hit[ksl_pkg::SLOT_W-1:0];
                end
                else
                begin
                    rep.status = ksl_pkg::ST_MISSING;
                end
            end
            ksl_pkg::CMD_LOOKUP:
            begin
                hit = find_key(r.id, r.root);
                if (hit >= 0)
                begin
                    rep.slot    = hit[ksl_pkg::SLOT_W-1:0];
                    rep.ftype   = slot_type[hit];
                    rep.fhandle = slot_handle[hit];
                end
                else
                begin
                    rep.status = ksl_pkg::ST_MISSING;
                end
            end
            default:
            begin
                wipe_table();
            end
        endcase
        awaited_replies.push_back(rep);
    endfunction

    function int pending();
        return awaited_replies.size();
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            flag($sformatf("result %0d %s: expected %0h, got %0h", taken, field, want, got));
    endfunction

    // Check one accepted result item against the oldest queued reply.
    function void check_reply(logic [ksl_pkg::OUT_DW-1:0] word);
        slot_reply_t want;
        taken++;
        if (awaited_replies.size() == 0)
        begin
            flag($sformatf("result %0d (%0h) arrived with nothing pending", taken, word));
            return;
        end
        want = awaited_replies.pop_front();
        compare("status", 32'(want.status), 32'(word[1:0]));
        compare("slot_index", 32'(want.slot), 32'(word[3:2]));
        compare("found_type", 32'(want.ftype), 32'(word[11:4]));
        compare("found_handle", 32'(want.fhandle), 32'(word[27:12]));
        compare("pad", 32'd0, 32'(word[ksl_pkg::OUT_DW-1:28]));
    endfunction
endclass

module keyed_slot_table_test;
    import ksl_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_ITEMS   = 200;   // tail of the run with no idling
    localparam int KEY_POOL     = 6;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int HOLD_AFTER   = 60;    // results taken before the hold-off
    localparam int DRAIN_CYCLES = 4 * (DEF_TABLE_SLOTS + 1);

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;   // command, query_id, query_type, payload_handle, root_addr
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;   // status, slot_index, found_type, found_handle

    slot_table_board         board;
    bit                      calm;
    bit                      held;
    logic [ID_W-1:0]         pool_id   [KEY_POOL];
    logic [ROOT_W-1:0]       pool_root [KEY_POOL];

    keyed_slot_table #(
        .TABLE_SLOTS (DEF_TABLE_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Pack one command item into tdata, first field in the lowest bits.
    function automatic logic [IN_DW-1:0] pack_command(req_t r);
        return {{(IN_DW - IN_BITS){1'b0}}, r.root, r.handle, r.typ, r.id, r.cmd};
    endfunction

    function automatic req_t make_command(cmd_t c, logic [ID_W-1:0] id,
                                          logic [TYPE_W-1:0] typ,
                                          logic [HANDLE_W-1:0] handle,
                                          logic [ROOT_W-1:0] root);
        req_t r;
        r.cmd    = c;
        r.id     = id;
        r.typ    = typ;
        r.handle = handle;
        r.root   = root;
        return r;
    endfunction

    // Mostly keys from a small pool so that adds, hits and a full table are common;
    // the rest are keys drawn over the whole range.
    function automatic req_t random_command();
        req_t r;
        int   pick;
        int   k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.cmd = CMD_ADD;
        else if (pick < 65)
            r.cmd = CMD_REMOVE;
        else if (pick < 94)
            r.cmd = CMD_LOOKUP;
        else
            r.cmd = CMD_CLEAR;
        r.typ    = TYPE_W'($urandom);
        r.handle = HANDLE_W'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            k      = $urandom_range(0, KEY_POOL - 1);
            r.id   = pool_id[k];
            r.root = pool_root[k];
        end
        else
        begin
            r.id   = ID_W'($urandom);
            r.root = ROOT_W'($urandom);
        end
        return r;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_command(req_t r);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pack_command(r);
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_command(r);
    endtask

    // Drop valid for a burst of cycles; tdata carries junk meanwhile.
    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = pack_command(random_command());
        end
    endtask

    // Timeout guard, several times the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, no stalls in the calm tail.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && board.taken >= HOLD_AFTER)
            begin
                held          = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left    = $urandom_range(0, 9);
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Take result items at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reply(m_axis_tdata);
    end

    // Stimulus: reset, directed corner cases, then random traffic.
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        held          = 1'b0;
        board         = new();

        // Build the key pool: some keys share an id or a root with another,
        // so that partial matches are exercised.
        for (int k = 0; k < KEY_POOL; k++)
        begin
            pool_id[k]   = ID_W'($urandom);
            pool_root[k] = ROOT_W'($urandom);
        end
        pool_id[1]   = pool_id[0];
        pool_root[2] = pool_root[0];
        pool_id[3]   = '0;
        pool_root[3] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: free slots must not match a zero key.
        send_command(make_command(CMD_LOOKUP, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_REMOVE, 8'h00, 8'hFF, 16'hFFFF, 16'h0000));
        // Fill every slot, including a duplicate key.
        send_command(make_command(CMD_ADD, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_command(make_command(CMD_ADD, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_ADD, 8'hFF, 8'h5A, 16'h1234, 16'hFFFF));
        send_command(make_command(CMD_ADD, 8'h01, 8'h80, 16'h8001, 16'h8000));
        // Table full.
        send_command(make_command(CMD_ADD, 8'hAA, 8'h55, 16'hA5A5, 16'h5A5A));
        // Duplicate key: the lowest copy answers, then the next one.
        send_command(make_command(CMD_LOOKUP, 8'hFF, 8'h00, 16'h0000, 16'hFFFF));
        send_command(make_command(CMD_REMOVE, 8'hFF, 8'h00, 16'h0000, 16'hFFFF));
        send_command(make_command(CMD_LOOKUP, 8'hFF, 8'h00, 16'h0000, 16'hFFFF));
        send_command(make_command(CMD_LOOKUP, 8'h00, 8'hFF, 16'hFFFF, 16'h0000));
        // Id matches, root does not; root matches, id does not.
        send_command(make_command(CMD_LOOKUP, 8'h01, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_LOOKUP, 8'h02, 8'h00, 16'h0000, 16'h8000));
        // Refill the freed slot, then remove a key and look it up again.
        send_command(make_command(CMD_ADD, 8'h7F, 8'h01, 16'h7FFF, 16'h0001));
        send_command(make_command(CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_LOOKUP, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_LOOKUP, 8'h7F, 8'h00, 16'h0000, 16'h0001));
        // Clear all, then the cleared keys are gone; clear an empty table too.
        send_command(make_command(CMD_CLEAR, 8'hC3, 8'h3C, 16'hBEEF, 16'h0F0F));
        send_command(make_command(CMD_LOOKUP, 8'h01, 8'h00, 16'h0000, 16'h8000));
        send_command(make_command(CMD_REMOVE, 8'hFF, 8'h00, 16'h0000, 16'hFFFF));
        send_command(make_command(CMD_CLEAR, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_command(make_command(CMD_ADD, 8'h80, 8'h7F, 16'h0001, 16'h7FFF));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 10));
            send_command(random_command());
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;

        // Drain every owed reply, then watch for stray results.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
